// ===== sv/sm4_block_cipher_modes_macros.svh =====
// Assertion macros used by the checker file.
`ifndef SM4_BLOCK_CIPHER_MODES_MACROS_SVH
`define SM4_BLOCK_CIPHER_MODES_MACROS_SVH

// Same-cycle implication, gated by reset.
`define SM4M_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, gated by reset.
`define SM4M_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/sm4m_pkg.sv =====
// ----------------------------------------------------------------------------
// sm4m_pkg
// Types, codes and tables for the SM4 modes block.
// ----------------------------------------------------------------------------
package sm4m_pkg;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_HIGH  = 3'd0,
    CFG_KEY_LOW   = 3'd1,
    CFG_IV_HIGH   = 3'd2,
    CFG_IV_LOW    = 3'd3,
    CFG_MODE      = 3'd4,
    CFG_DECRYPT   = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    MODE_ECB = 3'd0,
    MODE_CBC = 3'd1,
    MODE_CFB = 3'd2,
    MODE_OFB = 3'd3,
    MODE_CTR = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_KEYS,
    ST_ROUNDS,
    ST_DONE
  } core_state_t;

  // top -> core
  typedef struct packed {
    logic start;
    logic decrypt;
    logic rekey;
    logic ack;
  } core_ctrl_t;

  // core -> top
  typedef struct packed {
    logic idle;
    logic done;
  } core_stat_t;

  localparam logic [31:0] FK [4] = '{
    32'hA3B1BAC6, 32'h56AA3350, 32'h677D9197, 32'hB27022DC
  };

  localparam logic [7:0] SBOX [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  // CK word for key round i: byte j = (4i+j)*7 mod 256
  function automatic logic [31:0] ck_word(input logic [4:0] i);
    logic [31:0] w;
    logic [7:0]  b;
    w = '0;
    for (int j = 0; j < 4; j++) begin
      b = 8'({1'b0, i, 2'(j)}) * 8'd7;
      w = {w[23:0], b};
    end
    return w;
  endfunction

endpackage

// ===== sv/sm4m_block_if.sv =====
// ----------------------------------------------------------------------------
// sm4m_block_if
// Input word channel: one 128-bit block and a start-of-message flag.
// ----------------------------------------------------------------------------
interface sm4m_block_if;
  logic        valid;
  logic        ready;
  logic [63:0] block_high;
  logic [63:0] block_low;
  logic        first_block;

  modport source (output valid, block_high, block_low, first_block, input ready);
  modport sink   (input valid, block_high, block_low, first_block, output ready);
endinterface

// ===== sv/sm4m_result_if.sv =====
// ----------------------------------------------------------------------------
// sm4m_result_if
// Output word channel: one 128-bit result block.
// ----------------------------------------------------------------------------
interface sm4m_result_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_high;
  logic [63:0] result_low;

  modport source (output valid, result_high, result_low, input ready);
  modport sink   (input valid, result_high, result_low, output ready);
endinterface

// ===== sv/sm4m_tunit.sv =====
// ----------------------------------------------------------------------------
// sm4m_tunit
// Shared SM4 T transform: S-box layer then the round or key linear mix.
// ----------------------------------------------------------------------------
module sm4m_tunit (
  input  logic [31:0] din,
  input  logic        key_mix,
  output logic [31:0] dout
);
  import sm4m_pkg::*;

  logic [31:0] b;

  always_comb begin
    b = {SBOX[din[31:24]], SBOX[din[23:16]], SBOX[din[15:8]], SBOX[din[7:0]]};
    if (key_mix) begin
      dout = b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
    end else begin
      dout = b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]}
               ^ {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
    end
  end
endmodule

// ===== sv/sm4m_core.sv =====
// ----------------------------------------------------------------------------
// sm4m_core
// SM4 sequencer: key schedule and 32 rounds, one step per cycle on the T unit.
// ----------------------------------------------------------------------------
module sm4m_core (
  input  logic                 clk,
  input  logic                 rst,
  input  sm4m_pkg::core_ctrl_t ctrl,
  input  logic [127:0]         key,
  input  logic [127:0]         din,
  output sm4m_pkg::core_stat_t stat,
  output logic [127:0]         dout
);
  import sm4m_pkg::*;

  core_state_t state, state_next;
  logic [4:0]  cnt;
  logic        keys_valid;
  logic        decrypt;
  logic [31:0] x [4];
  logic [31:0] k [4];
  logic [31:0] rk [32];
  logic [31:0] t_in, t_out;
  logic [31:0] rk_sel;

  sm4m_tunit u_tunit (
    .din     (t_in),
    .key_mix (state == ST_KEYS),
    .dout    (t_out)
  );

  always_comb begin
    rk_sel = rk[decrypt ? ~cnt : cnt];
    if (state == ST_KEYS) t_in = k[1] ^ k[2] ^ k[3] ^ ck_word(cnt);
    else                  t_in = x[1] ^ x[2] ^ x[3] ^ rk_sel;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (ctrl.start) state_next = keys_valid ? ST_ROUNDS : ST_KEYS;
      ST_KEYS:   if (cnt == 5'd31) state_next = ST_ROUNDS;
      ST_ROUNDS: if (cnt == 5'd31) state_next = ST_DONE;
      ST_DONE:   if (ctrl.ack) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      keys_valid <= 1'b0;
      cnt        <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          cnt <= '0;
          if (ctrl.rekey) keys_valid <= 1'b0;
        end
        ST_KEYS: begin
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) keys_valid <= 1'b1;
        end
        ST_ROUNDS: cnt <= cnt + 5'd1;
        default:   cnt <= '0;
      endcase
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: if (ctrl.start) begin
        decrypt <= ctrl.decrypt;
        x[0] <= din[127:96];
        x[1] <= din[95:64];
        x[2] <= din[63:32];
        x[3] <= din[31:0];
        k[0] <= key[127:96] ^ FK[0];
        k[1] <= key[95:64]  ^ FK[1];
        k[2] <= key[63:32]  ^ FK[2];
        k[3] <= key[31:0]   ^ FK[3];
      end
      ST_KEYS: begin
        rk[cnt] <= k[0] ^ t_out;
        k[0] <= k[1];
        k[1] <= k[2];
        k[2] <= k[3];
        k[3] <= k[0] ^ t_out;
      end
      ST_ROUNDS: begin
        x[0] <= x[1];
        x[1] <= x[2];
        x[2] <= x[3];
        x[3] <= x[0] ^ t_out;
      end
      default: ;
    endcase
  end

  assign dout = {x[3], x[2], x[1], x[0]};
  assign stat = '{idle: (state == ST_IDLE), done: (state == ST_DONE)};
endmodule

// ===== sv/sm4_block_cipher_modes.sv =====
// ----------------------------------------------------------------------------
// sm4_block_cipher_modes
// SM4 in ECB, CBC, CFB, OFB and CTR, encrypt or decrypt, one block per word.
// ----------------------------------------------------------------------------
//  channel | dir | payload                              | handshake
//  req     | in  | block_high, block_low, first_block   | valid / ready
//  rsp     | out | result_high, result_low              | valid / ready
//  cfg     | in  | cfg_index, cfg_data                  | cfg_write, no stall
//
// Sequence: each word is accepted, run through 32 rounds on the shared
//   T unit and handed off; after reset or a key register write while idle,
//   the 32-step key schedule runs on the same T unit first.
// Reset: clears chain value, block index, mode regs and the key cache.
// Stalls: rsp has an output register; a new word is taken while a result
//   waits. The core holds a finished block until that register is free.
// ----------------------------------------------------------------------------
module sm4_block_cipher_modes (
  input  logic                            clk,
  input  logic                            rst,
  sm4m_block_if.sink                      req,
  sm4m_result_if.source                   rsp,
  input  logic                            cfg_write,
  input  logic [sm4m_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [63:0]                     cfg_data
);
  import sm4m_pkg::*;

  // configuration registers
  logic [63:0]  key_high, key_low, iv_high, iv_low;
  logic [2:0]   chain_mode;
  logic         decrypt_select;

  // message state
  logic [127:0] chain_value;
  logic [63:0]  block_index;
  logic [127:0] blk;          // input word held for the whole operation

  // output register
  logic         out_valid;
  logic [127:0] out_data;

  core_ctrl_t   ctrl;
  core_stat_t   stat;
  logic [127:0] core_din, core_dout;
  logic         core_decrypt;
  logic         core_rekey;
  logic         core_ack;

  logic         accept;
  logic [127:0] cv_eff;
  logic [63:0]  idx_eff;
  logic [127:0] in_blk;
  logic [127:0] res;
  logic [127:0] chain_next;

  assign accept    = req.valid && req.ready;
  assign req.ready = stat.idle;

  assign in_blk  = {req.block_high, req.block_low};
  assign cv_eff  = req.first_block ? {iv_high, iv_low} : chain_value;
  assign idx_eff = req.first_block ? 64'd0 : block_index;

  // what goes into the cipher, per mode
  always_comb begin
    core_decrypt = 1'b0;
    case (chain_mode)
      MODE_ECB: begin
        core_din     = in_blk;
        core_decrypt = decrypt_select;
      end
      MODE_CBC: begin
        core_din     = decrypt_select ? in_blk : (cv_eff ^ in_blk);
        core_decrypt = decrypt_select;
      end
      MODE_CFB, MODE_OFB: core_din = cv_eff;
      MODE_CTR:           core_din = {iv_low, idx_eff};
      default:            core_din = in_blk;
    endcase
  end

  assign core_rekey = cfg_write &&
                      (cfg_index == CFG_KEY_HIGH || cfg_index == CFG_KEY_LOW);
  assign core_ack   = stat.done && (!out_valid || rsp.ready);
  assign ctrl       = '{start: accept, decrypt: core_decrypt,
                        rekey: core_rekey, ack: core_ack};

  // result and feedback once the cipher is done
  always_comb begin
    chain_next = chain_value;
    case (chain_mode)
      MODE_ECB: res = core_dout;
      MODE_CBC: begin
        if (decrypt_select) begin
          res        = core_dout ^ chain_value;
          chain_next = blk;
        end else begin
          res        = core_dout;
          chain_next = core_dout;
        end
      end
      MODE_CFB: begin
        res        = core_dout ^ blk;
        chain_next = decrypt_select ? blk : (core_dout ^ blk);
      end
      MODE_OFB: begin
        res        = core_dout ^ blk;
        chain_next = core_dout;
      end
      MODE_CTR: res = core_dout ^ blk;
      default:  res = '0;
    endcase
  end

  sm4m_core u_core (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .key  ({key_high, key_low}),
    .din  (core_din),
    .stat (stat),
    .dout (core_dout)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high       <= '0;
      key_low        <= '0;
      iv_high        <= '0;
      iv_low         <= '0;
      chain_mode     <= MODE_ECB;
      decrypt_select <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_KEY_HIGH: key_high       <= cfg_data;
        CFG_KEY_LOW:  key_low        <= cfg_data;
        CFG_IV_HIGH:  iv_high        <= cfg_data;
        CFG_IV_LOW:   iv_low         <= cfg_data;
        CFG_MODE:     chain_mode     <= cfg_data[2:0];
        CFG_DECRYPT:  decrypt_select <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_value <= '0;
      block_index <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (accept) begin
        chain_value <= cv_eff;
        block_index <= idx_eff + 64'd1;
      end else if (core_ack) begin
        chain_value <= chain_next;
      end
      if (core_ack)           out_valid <= 1'b1;
      else if (rsp.ready)     out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept)   blk      <= in_blk;
    if (core_ack) out_data <= res;
  end

  assign rsp.valid       = out_valid;
  assign rsp.result_high = out_data[127:64];
  assign rsp.result_low  = out_data[63:0];
endmodule

// ===== sv/sm4m_checker.sv =====
// ----------------------------------------------------------------------------
// sm4m_checker
// Port-level checks for the SM4 modes block, bound to the top level.
// ----------------------------------------------------------------------------
`include "sm4_block_cipher_modes_macros.svh"

module sm4m_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic cfg_write
);
  logic in_acc;
  assign in_acc = in_valid && in_ready;

  `SM4M_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid, "result dropped")
  `SM4M_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_acc, !in_ready, "ready after accept")
  `SM4M_ASSERT_NEXT(a_no_instant_result, clk, rst, in_acc, !$rose(out_valid), "result too early")
  `SM4M_ASSERT_NEXT(a_stay_busy, clk, rst, in_acc ##1 1'b1, !in_ready, "short operation")
  `SM4M_ASSERT_NOW(a_cfg_when_idle, clk, rst, cfg_write, in_ready, "config write while busy")
endmodule

bind sm4_block_cipher_modes sm4m_checker u_sm4m_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (req.valid),
  .in_ready  (req.ready),
  .out_valid (rsp.valid),
  .out_ready (rsp.ready),
  .cfg_write (cfg_write)
);
